### hw/rtl/b58_pkg.sv
package b58_pkg;

  localparam int PAYLOAD_BYTES_DEF = 25;
  localparam int RADIX = 58;
  localparam logic [6:0] PREFIX_CHAR = 7'd49;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DIV,
    ST_PREFIX,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_byte;
    logic start_div;
    logic div_step;
    logic load_prefix;
    logic load_digit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pass_end;
    logic quot_zero;
    logic out_free;
    logic idx_zero;
  } dp_status_t;

  // one digit step of the long division: {quotient byte, remainder}
  function automatic logic [13:0] div58_step(input logic [13:0] cur);
    logic [23:0] prod;
    logic [7:0]  q;
    logic [13:0] qm;
    logic [13:0] r;
    prod = 24'(cur) * 24'd565;
    q    = prod[22:15];
    qm   = 14'(q) * 14'(RADIX);
    r    = cur - qm;
    return {q, r[5:0]};
  endfunction

  function automatic logic [6:0] alphabet58(input logic [5:0] d);
    logic [6:0] c;
    if (d < 6'd9) begin
      c = 7'd49 + 7'(d);
    end else if (d < 6'd17) begin
      c = 7'd65 + 7'(d - 6'd9);
    end else if (d < 6'd22) begin
      c = 7'd74 + 7'(d - 6'd17);
    end else if (d < 6'd33) begin
      c = 7'd80 + 7'(d - 6'd22);
    end else if (d < 6'd44) begin
      c = 7'd97 + 7'(d - 6'd33);
    end else if (d < 6'd58) begin
      c = 7'd109 + 7'(d - 6'd44);
    end else begin
      c = PREFIX_CHAR;
    end
    return c;
  endfunction

endpackage

### hw/rtl/b58_ctrl.sv
module b58_ctrl
  import b58_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tlast,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       s_tready
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (s_tvalid && s_tlast) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.pass_end && status.quot_zero) state_next = ST_PREFIX;
      end
      ST_PREFIX: begin
        if (status.out_free) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free && status.idx_zero) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_LOAD: begin
        s_tready      = 1'b1;
        cmd.load_byte = s_tvalid;
        cmd.start_div = s_tvalid && s_tlast;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_PREFIX: begin
        cmd.load_prefix = status.out_free;
      end
      ST_EMIT: begin
        cmd.load_digit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hw/rtl/b58_datapath.sv
module b58_datapath
  import b58_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  ctrl_cmd_t  cmd,
  input  logic [7:0] byte_value,
  input  logic       m_tready,
  output dp_status_t status,
  output logic       m_tvalid,
  output logic [6:0] char_code,
  output logic       last_char
);

  localparam int VW  = 8 * PAYLOAD_BYTES;
  localparam int BCW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int DC  = 2 * PAYLOAD_BYTES + 1;
  localparam int DCW = $clog2(DC + 1);
  localparam int AW  = $clog2(DC);

  logic [VW-1:0]  value;
  logic [BCW-1:0] byte_cnt;
  logic [5:0]     rem;
  logic           nz;
  logic [DCW-1:0] digit_cnt;
  logic [AW-1:0]  rd_idx;
  logic [5:0]     rd_data;
  logic [5:0]     digit_mem [DC];

  logic [13:0]    step;
  logic [7:0]     q;
  logic [5:0]     r;
  logic           pass_end;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [DCW-1:0] cnt_m1;

  assign step     = div58_step({rem, value[VW-1 -: 8]});
  assign q        = step[13:6];
  assign r        = step[5:0];
  assign pass_end = (byte_cnt == BCW'(PAYLOAD_BYTES - 1));
  assign cnt_m1   = digit_cnt - DCW'(1);

  assign status.pass_end  = pass_end;
  assign status.quot_zero = !(nz || (q != 8'd0));
  assign status.out_free  = !m_tvalid || m_tready;
  assign status.idx_zero  = (rd_idx == '0);

  // value register: bytes enter at the bottom, quotient bytes rotate in
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (cmd.load_byte) begin
      value <= (value << 8) | VW'(byte_value);
    end else if (cmd.div_step) begin
      value <= (value << 8) | VW'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_cnt  <= '0;
      rem       <= '0;
      nz        <= 1'b0;
      digit_cnt <= '0;
    end else if (cmd.start_div) begin
      byte_cnt  <= '0;
      rem       <= '0;
      nz        <= 1'b0;
      digit_cnt <= '0;
    end else if (cmd.div_step) begin
      if (pass_end) begin
        byte_cnt <= '0;
        rem      <= '0;
        nz       <= 1'b0;
        if (digit_cnt < DCW'(DC)) digit_cnt <= digit_cnt + DCW'(1);
      end else begin
        byte_cnt <= byte_cnt + BCW'(1);
        rem      <= r;
        nz       <= nz || (q != 8'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step && pass_end && (digit_cnt < DCW'(DC))) begin
      digit_mem[digit_cnt[AW-1:0]] <= r;
    end
  end

  always_comb begin
    rd_en   = cmd.load_prefix || (cmd.load_digit && (rd_idx != '0));
    rd_addr = cmd.load_prefix ? cnt_m1[AW-1:0] : rd_idx - AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= digit_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx <= rd_addr;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_prefix || cmd.load_digit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_prefix) begin
      char_code <= PREFIX_CHAR;
      last_char <= 1'b0;
    end else if (cmd.load_digit) begin
      char_code <= alphabet58(rd_data);
      last_char <= (rd_idx == '0);
    end
  end

endmodule

### hw/rtl/base58_payload_encoder.sv
// loading: one byte per cycle; a byte without tlast gives no output
// after the byte with tlast: D passes over all PAYLOAD_BYTES bytes (one byte per cycle
// through the divide-by-58 step), D = digit count, at most about 1.37*PAYLOAD_BYTES + 1
// then prefix and D characters, one per cycle while m_tready is high
// rst (synchronous) clears the controller, the number and the output valid;
// the digit memory needs no clearing
module base58_payload_encoder
  import b58_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] byte_value
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] char_code, [7] zero
  output logic       m_tlast    // last_char
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic [6:0] char_code;

  b58_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .status   (status),
    .cmd      (cmd),
    .s_tready (s_tready)
  );

  b58_datapath #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .byte_value (s_tdata),
    .m_tready   (m_tready),
    .status     (status),
    .m_tvalid   (m_tvalid),
    .char_code  (char_code),
    .last_char  (m_tlast)
  );

  assign m_tdata = {1'b0, char_code};

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (char_code >= 7'd49) && (char_code <= 7'd122))
    else $error("character code out of alphabet range");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("request taken while encoding");

  a_ready_after_final: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_digit && status.idx_zero) |=> s_tready && m_tvalid && m_tlast)
    else $error("final character not flagged or loader not freed");

endmodule
